/* hdl/qse_pkg.sv */
// Package for the quadrature speed estimator: field widths, codes, limits and
// the command and status structs between the controller and the datapath.
// No dependencies.
package qse_pkg;

  localparam int CHANNELS = 3;

  localparam int POS_W    = 32;
  localparam int DELTA_W  = 16;
  localparam int SPEED_W  = 24;
  localparam int CHAN_W   = 2;
  localparam int PHASE_W  = CHANNELS;
  localparam int RATE_W   = 9;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 9;

  localparam logic KIND_PIN  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [CFG_A_W-1:0] CFG_BOTH_EDGES = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_RATE       = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 9'd102;
  localparam logic [RATE_W-1:0] RATE_ONE   = 9'd256;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

  typedef struct packed {
    logic pin_upd;
    logic load;
    logic mul;
    logic sum;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/qse_if.sv */
// Channel interfaces of the quadrature speed estimator: pin and tick input,
// per-channel result output, and the configuration write channel.
// Depends on qse_pkg.
interface qse_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [qse_pkg::PHASE_W-1:0] a_phase;
  logic [qse_pkg::PHASE_W-1:0] b_phase;
  modport source (output valid, kind, a_phase, b_phase, input ready);
  modport sink (input valid, kind, a_phase, b_phase, output ready);
endinterface

interface qse_out_if;
  logic                               valid;
  logic                               ready;
  logic        [qse_pkg::CHAN_W-1:0]  channel;
  logic signed [qse_pkg::POS_W-1:0]   position;
  logic signed [qse_pkg::DELTA_W-1:0] delta;
  logic signed [qse_pkg::SPEED_W-1:0] smoothed_speed;
  logic                               last;
  modport source (output valid, channel, position, delta, smoothed_speed, last,
                  input ready);
  modport sink (input valid, channel, position, delta, smoothed_speed, last,
                output ready);
endinterface

interface qse_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qse_pkg::CFG_A_W-1:0] addr;
  logic [qse_pkg::CFG_D_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* hdl/qse_ctrl.sv */
// Controller of the quadrature speed estimator: takes input transfers and
// sequences the per-channel speed update of a tick through the datapath.
// Depends on qse_pkg and qse_if.
module qse_ctrl #(
  parameter int CHANNELS = 3,
  parameter int CH_W     = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  qse_in_if.sink           in_ch,
  input  qse_pkg::dp_sts_t sts,
  output qse_pkg::dp_cmd_t cmd,
  output logic [CH_W-1:0]  ch
);
  import qse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } state_t;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            is_last;

  assign is_last      = (ch_r == CH_LAST);
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign ch           = ch_r;

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    cmd         = '0;
    cmd.last    = is_last;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == KIND_TICK) begin
            state_nxt = ST_LOAD;
            ch_nxt    = '0;
          end else begin
            cmd.pin_upd = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.sum = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_sum_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum |-> sts.out_free)
    else $error("result written while the output register is occupied");

  a_load_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.mul)
    else $error("multiply step did not follow a load");

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CH_LAST)
    else $error("channel counter out of range");

  a_no_pin_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pin_upd |-> !(cmd.load || cmd.mul || cmd.sum))
    else $error("pin update during a tick");

endmodule

/* hdl/qse_dp.sv */
// Datapath of the quadrature speed estimator: per-channel counters, tick
// snapshot, smoothing multipliers, configuration registers and output register.
// Depends on qse_pkg and qse_if.
module qse_dp #(
  parameter int CHANNELS    = 3,
  parameter int COUNT_WIDTH = 32,
  parameter int CH_W        = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qse_pkg::dp_cmd_t             cmd,
  input  logic [CH_W-1:0]              ch,
  output qse_pkg::dp_sts_t             sts,
  input  logic [qse_pkg::PHASE_W-1:0]  a_phase,
  input  logic [qse_pkg::PHASE_W-1:0]  b_phase,
  qse_cfg_if.sink                      cfg_ch,
  qse_out_if.source                    out_ch
);
  import qse_pkg::*;

  localparam int W = COUNT_WIDTH;

  logic [W-1:0]               pos_r [CHANNELS];
  logic [W-1:0]               plt_r [CHANNELS];
  logic signed [SPEED_W-1:0]  spd_r [CHANNELS];
  logic [CHANNELS-1:0]        prev_a_r;
  logic [W-1:0]               pos_nxt [CHANNELS];
  logic                       both_r;
  logic [RATE_W-1:0]          rate_r;
  logic                       out_valid_r;

  logic [7:0]                 a_ext, b_ext;
  logic [RATE_W-1:0]          rate_eff, rate_inv;
  logic [W-1:0]               pos_sel, diff;
  logic signed [32:0]         diff_x;
  logic signed [DELTA_W-1:0]  d_sat;

  logic signed [POS_W-1:0]    cur_pos_r;
  logic signed [DELTA_W-1:0]  cur_d_r;
  logic signed [SPEED_W-1:0]  cur_spd_r;
  logic signed [25:0]         p1_r;
  logic signed [33:0]         p2_r;
  logic signed [26:0]         sum;
  logic signed [SPEED_W-1:0]  spd_sat;

  logic [CHAN_W-1:0]          out_chan_r;
  logic signed [POS_W-1:0]    out_pos_r;
  logic signed [DELTA_W-1:0]  out_d_r;
  logic signed [SPEED_W-1:0]  out_spd_r;
  logic                       out_last_r;

  assign a_ext = 8'(a_phase);
  assign b_ext = 8'(b_phase);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      pos_nxt[i] = pos_r[i];
      if (a_ext[i] && !prev_a_r[i]) begin
        pos_nxt[i] = b_ext[i] ? pos_r[i] + W'(1) : pos_r[i] - W'(1);
      end else if (!a_ext[i] && prev_a_r[i] && both_r) begin
        pos_nxt[i] = b_ext[i] ? pos_r[i] - W'(1) : pos_r[i] + W'(1);
      end
    end
  end

  assign rate_eff = (rate_r > RATE_ONE) ? RATE_ONE : rate_r;
  assign rate_inv = RATE_ONE - rate_eff;

  assign pos_sel = pos_r[ch];
  assign diff    = pos_sel - plt_r[ch];
  assign diff_x  = 33'(signed'(diff));

  always_comb begin
    if (diff_x > 33'(DELTA_MAX)) begin
      d_sat = DELTA_MAX;
    end else if (diff_x < 33'(DELTA_MIN)) begin
      d_sat = DELTA_MIN;
    end else begin
      d_sat = diff_x[DELTA_W-1:0];
    end
  end

  assign sum = 27'(p1_r) + 27'(p2_r >>> 8);

  always_comb begin
    if (sum > 27'(SPEED_MAX)) begin
      spd_sat = SPEED_MAX;
    end else if (sum < 27'(SPEED_MIN)) begin
      spd_sat = SPEED_MIN;
    end else begin
      spd_sat = sum[SPEED_W-1:0];
    end
  end

  assign sts.out_free = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= '0;
        plt_r[i] <= '0;
        spd_r[i] <= '0;
      end
      prev_a_r    <= '0;
      both_r      <= 1'b0;
      rate_r      <= RATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          CFG_BOTH_EDGES: both_r <= cfg_ch.data[0];
          CFG_RATE:       rate_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (cmd.pin_upd) begin
        for (int i = 0; i < CHANNELS; i++) begin
          pos_r[i] <= pos_nxt[i];
        end
        prev_a_r <= a_ext[CHANNELS-1:0];
      end
      if (cmd.load) begin
        plt_r[ch] <= pos_sel;
      end
      if (cmd.sum) begin
        spd_r[ch]   <= spd_sat;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_pos_r <= 32'(signed'(pos_sel));
      cur_d_r   <= d_sat;
      cur_spd_r <= spd_r[ch];
    end
    if (cmd.mul) begin
      p1_r <= cur_d_r * signed'({1'b0, rate_eff});
      p2_r <= cur_spd_r * signed'({1'b0, rate_inv});
    end
    if (cmd.sum) begin
      out_chan_r <= CHAN_W'(ch);
      out_pos_r  <= cur_pos_r;
      out_d_r    <= cur_d_r;
      out_spd_r  <= spd_sat;
      out_last_r <= cmd.last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel        = out_chan_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.delta          = out_d_r;
  assign out_ch.smoothed_speed = out_spd_r;
  assign out_ch.last           = out_last_r;

endmodule

/* hdl/quadrature_speed_estimator.sv */
// Top level of the quadrature speed estimator: controller plus datapath.
// Depends on qse_pkg, qse_if, qse_ctrl and qse_dp.
//
//   port     | direction | carries
//   in_ch    | sink      | kind, a_phase, b_phase (pin sample or sampling tick)
//   out_ch   | source    | channel, position, delta, smoothed_speed, last
//   cfg_ch   | sink      | addr, data (count_both_edges, smoothing_rate)
//
// A pin sample updates every channel at once.
// A tick steps each channel in turn through snapshot, multiply, and sum and
// write after its accepting cycle, reusing the shared smoothing multipliers.
// The output register lets a tick finish and pin samples continue while the
// last result waits; a stalled output holds the tick in its sum step.
// Reset is synchronous. It clears counters, snapshots, speeds and output
// valid, and loads the smoothing rate with RATE_RESET.
module quadrature_speed_estimator #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  qse_in_if.sink    in_ch,
  qse_out_if.source out_ch,
  qse_cfg_if.sink   cfg_ch
);
  import qse_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [CH_W-1:0] ch;

  qse_ctrl #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd),
    .ch    (ch)
  );

  qse_dp #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CH_W        (CH_W)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .ch      (ch),
    .sts     (sts),
    .a_phase (in_ch.a_phase),
    .b_phase (in_ch.b_phase),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule
